// ===== rtl/assert_macros.svh =====
// Assertion macros used by the parser executor (sgr_back).
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SGR_NEVER(lbl, cond, msg) \
  `SGR_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/sgr_pkg.sv =====
// Shared types, codes and colour tables for the escape-sequence parser.
// No dependencies; imported by every parser module.
package sgr_pkg;

  // Command kinds handed from the classifier to the executor
  typedef enum logic [2:0] {
    OP_TEXT,
    OP_SWALLOW,
    OP_CSI_START,
    OP_DIGIT,
    OP_SEMI,
    OP_SGR,
    OP_CLEAR,
    OP_FINAL
  } sgr_op_e;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_HOME  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_EOL   = 2'd3;

  typedef struct packed {
    sgr_op_e    op;
    logic [1:0] act;
    logic [7:0] data;
  } cmd_t;

  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_LBRK  = 8'h5B;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;
  localparam logic [7:0] BYTE_SEMI  = 8'h3B;
  localparam logic [7:0] BYTE_M     = 8'h6D;
  localparam logic [7:0] BYTE_H     = 8'h48;
  localparam logic [7:0] BYTE_F     = 8'h66;
  localparam logic [7:0] BYTE_J     = 8'h4A;
  localparam logic [7:0] BYTE_K     = 8'h4B;

  localparam logic [15:0] SGR_RESET      = 16'd0;
  localparam logic [15:0] SGR_BOLD       = 16'd1;
  localparam logic [15:0] SGR_NORMAL     = 16'd22;
  localparam logic [15:0] SGR_FG_BASE    = 16'd30;
  localparam logic [15:0] SGR_FG_DEFAULT = 16'd39;
  localparam logic [15:0] SGR_BG_BASE    = 16'd40;
  localparam logic [15:0] SGR_BG_DEFAULT = 16'd49;
  localparam logic [15:0] SGR_FG_HI_BASE = 16'd90;
  localparam logic [15:0] SGR_BG_HI_BASE = 16'd100;
  localparam logic [15:0] SGR_CLEAR_ALL  = 16'd2;
  localparam logic [15:0] ACC_MAX        = 16'hFFFF;

  localparam logic [23:0] RESET_FG = 24'hFFFFFF;
  localparam logic [23:0] RESET_BG = 24'h000000;

  // Configuration register indexes
  localparam logic [0:0] CFG_INIT_FG = 1'b0;
  localparam logic [0:0] CFG_INIT_BG = 1'b1;

  // Normal and bright 8-colour palettes
  function automatic logic [23:0] sgr_palette(input logic bright, input logic [2:0] idx);
    logic [23:0] rgb;
    case ({bright, idx})
      4'h0:    rgb = 24'h000000;
      4'h1:    rgb = 24'hAA0000;
      4'h2:    rgb = 24'h00AA00;
      4'h3:    rgb = 24'hAA5500;
      4'h4:    rgb = 24'h0000AA;
      4'h5:    rgb = 24'hAA00AA;
      4'h6:    rgb = 24'h00AAAA;
      4'h7:    rgb = 24'hAAAAAA;
      4'h8:    rgb = 24'h555555;
      4'h9:    rgb = 24'hFF5555;
      4'hA:    rgb = 24'h55FF55;
      4'hB:    rgb = 24'hFFFF55;
      4'hC:    rgb = 24'h5555FF;
      4'hD:    rgb = 24'hFF55FF;
      4'hE:    rgb = 24'h55FFFF;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

endpackage

// ===== rtl/sgr_front.sv =====
// Byte classifier: tracks the escape phase and turns each byte into a command.
// Depends on sgr_pkg.
module sgr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  output sgr_pkg::cmd_t cmd_o
);
  import sgr_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;

  logic [1:0] phase_q, phase_d;
  cmd_t       cmd;

  always_comb begin
    phase_d  = phase_q;
    cmd.op   = OP_SWALLOW;
    cmd.act  = ACT_NONE;
    cmd.data = in_byte_i;
    case (phase_q)
      PH_IDLE: begin
        if (in_byte_i == BYTE_ESC) begin
          phase_d = PH_ESC;
        end else begin
          cmd.op = OP_TEXT;
        end
      end
      PH_ESC: begin
        if (in_byte_i == BYTE_LBRK) begin
          cmd.op  = OP_CSI_START;
          phase_d = PH_CSI;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_CSI: begin
        if (in_byte_i >= BYTE_ZERO && in_byte_i <= BYTE_NINE) begin
          cmd.op = OP_DIGIT;
        end else if (in_byte_i == BYTE_SEMI) begin
          cmd.op = OP_SEMI;
        end else begin
          phase_d = PH_IDLE;
          if (in_byte_i == BYTE_M) begin
            cmd.op = OP_SGR;
          end else if (in_byte_i == BYTE_J) begin
            cmd.op = OP_CLEAR;
          end else begin
            cmd.op = OP_FINAL;
            if (in_byte_i == BYTE_H || in_byte_i == BYTE_F) begin
              cmd.act = ACT_HOME;
            end else if (in_byte_i == BYTE_K) begin
              cmd.act = ACT_EOL;
            end
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else if (accept_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

// ===== rtl/sgr_cmd_fifo.sv =====
// Short command queue between the classifier and the executor.
// Depends on sgr_pkg for the command type.
module sgr_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  sgr_pkg::cmd_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output sgr_pkg::cmd_t rd_data_o,
  output logic          empty_o
);
  import sgr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;
  logic          do_wr, do_rd;

  assign full_o    = (count_q == CW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rptr_q];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wrap_inc(wptr_q);
      end
      if (do_rd) begin
        rptr_q <= wrap_inc(rptr_q);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/sgr_back.sv =====
// Command executor: parameter collection, SGR walk, colour state, result register.
// Depends on sgr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sgr_back #(
  parameter int MAX_PARAMS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sgr_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_index_i,
  input  logic [23:0]   cfg_data_i,
  input  logic          pop,
  output logic          empty,
  output logic          swallowed_o,
  output logic [1:0]    action_o,
  output logic [7:0]    pass_byte_o,
  output logic [23:0]   fg_color_o,
  output logic [23:0]   bg_color_o
);
  import sgr_pkg::*;

  localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int TW = $clog2(MAX_PARAMS + 1);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic          state_q, state_d;
  logic [15:0]   param_q [MAX_PARAMS];
  logic [TW-1:0] total_q, total_d;
  logic [IW-1:0] walk_q, walk_d;
  logic [15:0]   acc_q, acc_d;
  logic          seen_q, seen_d;
  logic          bright_q, bright_d;
  logic [23:0]   cur_fg_q, cur_fg_d, cur_bg_q, cur_bg_d;
  logic [23:0]   def_fg_q, def_fg_d, def_bg_q, def_bg_d;

  logic          out_valid_q, out_valid_d;
  logic          out_swal_q, out_swal_d;
  logic [1:0]    out_act_q, out_act_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic [23:0]   out_fg_q, out_fg_d, out_bg_q, out_bg_d;

  logic          out_free, take, push_en, push_we, walk_last, clear_hit;
  logic [15:0]   push_val, p;
  logic [19:0]   acc_wide;
  logic          s_bright;
  logic [23:0]   s_fg, s_bg;

  assign out_free  = !out_valid_q || pop;
  assign take      = (state_q == ST_RUN) && !cmd_empty_i && out_free;
  assign cmd_pop_o = take;

  assign push_val = seen_q ? acc_q : 16'd0;
  assign push_we  = push_en && (total_q < TW'(MAX_PARAMS));
  assign acc_wide = 20'(acc_q) * 20'd10 + 20'(cmd_i.data[3:0]);

  // J clears when no parameter was given or the first one is 2
  assign clear_hit = (total_q == '0) ? (!seen_q || acc_q == SGR_CLEAR_ALL)
                                     : (param_q[0] == SGR_CLEAR_ALL);

  assign p         = param_q[walk_q];
  assign walk_last = (TW'(walk_q) + TW'(1)) == total_q;

  // One SGR code against the current colour state
  always_comb begin
    s_bright = bright_q;
    s_fg     = cur_fg_q;
    s_bg     = cur_bg_q;
    if (p == SGR_RESET) begin
      s_fg     = def_fg_q;
      s_bg     = def_bg_q;
      s_bright = 1'b0;
    end else if (p == SGR_BOLD) begin
      s_bright = 1'b1;
    end else if (p == SGR_NORMAL) begin
      s_bright = 1'b0;
    end else if (p >= SGR_FG_BASE && p <= SGR_FG_BASE + 16'd7) begin
      s_fg = sgr_palette(bright_q, 3'(p - SGR_FG_BASE));
    end else if (p >= SGR_FG_HI_BASE && p <= SGR_FG_HI_BASE + 16'd7) begin
      s_fg = sgr_palette(1'b1, 3'(p - SGR_FG_HI_BASE));
    end else if (p >= SGR_BG_BASE && p <= SGR_BG_BASE + 16'd7) begin
      s_bg = sgr_palette(1'b0, 3'(p - SGR_BG_BASE));
    end else if (p >= SGR_BG_HI_BASE && p <= SGR_BG_HI_BASE + 16'd7) begin
      s_bg = sgr_palette(1'b1, 3'(p - SGR_BG_HI_BASE));
    end else if (p == SGR_FG_DEFAULT) begin
      s_fg = def_fg_q;
    end else if (p == SGR_BG_DEFAULT) begin
      s_bg = def_bg_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    walk_d      = walk_q;
    acc_d       = acc_q;
    seen_d      = seen_q;
    bright_d    = bright_q;
    cur_fg_d    = cur_fg_q;
    cur_bg_d    = cur_bg_q;
    def_fg_d    = def_fg_q;
    def_bg_d    = def_bg_q;
    push_en     = 1'b0;
    out_valid_d = out_valid_q && !pop;
    out_swal_d  = out_swal_q;
    out_act_d   = out_act_q;
    out_byte_d  = out_byte_q;
    out_fg_d    = out_fg_q;
    out_bg_d    = out_bg_q;

    if (take) begin
      out_valid_d = 1'b1;
      out_swal_d  = 1'b1;
      out_act_d   = ACT_NONE;
      out_byte_d  = 8'd0;
      case (cmd_i.op)
        OP_TEXT: begin
          out_swal_d = 1'b0;
          out_byte_d = cmd_i.data;
        end
        OP_CSI_START: begin
          total_d = '0;
          acc_d   = 16'd0;
          seen_d  = 1'b0;
        end
        OP_DIGIT: begin
          acc_d  = (acc_wide > 20'(ACC_MAX)) ? ACC_MAX : acc_wide[15:0];
          seen_d = 1'b1;
        end
        OP_SEMI: begin
          push_en = 1'b1;
          acc_d   = 16'd0;
          seen_d  = 1'b0;
        end
        OP_SGR: begin
          // store the pending code, then walk the list; result comes at the end
          push_en     = 1'b1;
          out_valid_d = 1'b0;
          walk_d      = '0;
          state_d     = ST_WALK;
        end
        OP_CLEAR: begin
          push_en = seen_q;
          if (clear_hit) begin
            out_act_d = ACT_CLEAR;
            bright_d  = 1'b0;
            def_fg_d  = cur_fg_q;
            def_bg_d  = cur_bg_q;
          end
        end
        OP_FINAL: begin
          push_en   = seen_q;
          out_act_d = cmd_i.act;
        end
        default: begin
        end
      endcase
      if (push_we) begin
        total_d = total_q + TW'(1);
      end
    end else if (state_q == ST_WALK && (!walk_last || out_free)) begin
      bright_d = s_bright;
      cur_fg_d = s_fg;
      cur_bg_d = s_bg;
      walk_d   = walk_q + IW'(1);
      if (walk_last) begin
        state_d     = ST_RUN;
        out_valid_d = 1'b1;
        out_swal_d  = 1'b1;
        out_act_d   = ACT_NONE;
        out_byte_d  = 8'd0;
      end
    end

    // Configuration writes must arrive only while the block is idle; the block itself does not enforce this
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INIT_FG: begin
          cur_fg_d = cfg_data_i;
          def_fg_d = cfg_data_i;
        end
        CFG_INIT_BG: begin
          cur_bg_d = cfg_data_i;
          def_bg_d = cfg_data_i;
        end
        default: begin
        end
      endcase
    end

    if (take || state_q == ST_WALK) begin
      out_fg_d = cur_fg_d;
      out_bg_d = cur_bg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_we) begin
      param_q[total_q[IW-1:0]] <= push_val;
    end
    out_swal_q <= out_swal_d;
    out_act_q  <= out_act_d;
    out_byte_q <= out_byte_d;
    out_fg_q   <= out_fg_d;
    out_bg_q   <= out_bg_d;
    walk_q     <= walk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      total_q     <= '0;
      acc_q       <= 16'd0;
      seen_q      <= 1'b0;
      bright_q    <= 1'b0;
      cur_fg_q    <= RESET_FG;
      cur_bg_q    <= RESET_BG;
      def_fg_q    <= RESET_FG;
      def_bg_q    <= RESET_BG;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      acc_q       <= acc_d;
      seen_q      <= seen_d;
      bright_q    <= bright_d;
      cur_fg_q    <= cur_fg_d;
      cur_bg_q    <= cur_bg_d;
      def_fg_q    <= def_fg_d;
      def_bg_q    <= def_bg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty       = !out_valid_q;
  assign swallowed_o = out_swal_q;
  assign action_o    = out_act_q;
  assign pass_byte_o = out_byte_q;
  assign fg_color_o  = out_fg_q;
  assign bg_color_o  = out_bg_q;

  `SGR_ASSERT(a_walk_in_range, (state_q == ST_WALK) |-> (TW'(walk_q) < total_q), "walk past list")
  `SGR_NEVER(a_total_bound, total_q > TW'(MAX_PARAMS), "parameter count overflow")
  `SGR_ASSERT(a_walk_ends_result, (state_q == ST_WALK && walk_last && out_free) |=> (out_valid_q && state_q == ST_RUN), "SGR walk ended without result")
  `SGR_NEVER(a_no_take_in_walk, (state_q == ST_WALK) && cmd_pop_o, "command taken during walk")

endmodule

// ===== rtl/ansi_sgr_escape_parser_unit.sv =====
// Top level of the escape-sequence parser with SGR colour handling.
// Depends on sgr_pkg, sgr_front, sgr_cmd_fifo and sgr_back.
//
// Use: text bytes enter on in_byte_i through a queue-style port; a transaction
// is taken at a rising edge with push high and full low. Every byte gives
// exactly one result, read from the output queue port: the oldest result sits
// on swallowed_o, action_o, pass_byte_o, fg_color_o and bg_color_o while empty
// is low, and is consumed at an edge with pop high.
// Configuration: write init_fg (index 0) or init_bg (index 1) over the cfg
// channel; cfg_ready_o is always high. A write loads the default and current
// colours at once. Write only while the parser is idle.
// Flow: the classifier writes a command into a short queue at the accepting
// edge; the executor then takes it from the queue and registers the result,
// so each result passes the command queue and the result register before it
// reaches the output ports. For an SGR final byte the executor walks the
// stored parameter list (up to MAX_PARAMS entries) one entry per cycle; it
// holds on the last entry while the result register is still full.
// Stall: when pop stays low the result register holds, the executor stops,
// the command queue fills and full rises; nothing is dropped.
// Reset: phase idle, queues empty, colours white on black, bright off.
module ansi_sgr_escape_parser_unit #(
  parameter int MAX_PARAMS  = 8,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic        swallowed_o,
  output logic [1:0]  action_o,
  output logic [7:0]  pass_byte_o,
  output logic [23:0] fg_color_o,
  output logic [23:0] bg_color_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import sgr_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic accept, q_empty, q_pop;

  // Take a byte whenever the command queue has room
  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  sgr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .cmd_o     (front_cmd)
  );

  sgr_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_i      (q_pop),
    .rd_data_o (back_cmd),
    .empty_o   (q_empty)
  );

  sgr_back #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_empty_i (q_empty),
    .cmd_pop_o   (q_pop),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pop         (pop),
    .empty       (empty),
    .swallowed_o (swallowed_o),
    .action_o    (action_o),
    .pass_byte_o (pass_byte_o),
    .fg_color_o  (fg_color_o),
    .bg_color_o  (bg_color_o)
  );

endmodule
